>>> hw/rtl/bpiou_pkg.sv
package bpiou_pkg;

  // input word layout (low bit first)
  localparam int CW       = 16;  // center width
  localparam int SW       = 15;  // size width
  localparam int IN_W     = 128;
  localparam int OUT_W    = 16;

  // doubled-scale corners, extents, areas
  localparam int CRN_W    = 18;
  localparam int EXT_W    = 16;
  localparam int AREA_W   = 32;
  localparam int UNI_W    = 33;
  localparam int REM_W    = 34;

  localparam int RATIO_W  = 16;
  localparam int DIV_STEPS = RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(32768);

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [UNI_W-1:0]   den;
    logic [RATIO_W-1:0] quo;
    logic               empty;
  } div_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               empty;
  } res_t;

  // one restoring step; the first step takes no shift since overlap <= union
  function automatic div_t div_step(input div_t d, input logic first);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] den_x;
    div_t o;
    t     = first ? d.rem : {d.rem[REM_W-2:0], 1'b0};
    den_x = {1'b0, d.den};
    o     = d;
    if (t >= den_x) begin
      o.rem = t - den_x;
      o.quo = {d.quo[RATIO_W-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {d.quo[RATIO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/box_pair_iou.sv
// box_pair_iou: intersection over union of two center-format boxes.
//
// Input channel in_*: one word per box pair. in_tdata carries both boxes
// (centers signed Q11.4, sizes unsigned Q11.4). Result channel out_*: one
// word per input word, in order. out_tdata is the ratio in unsigned Q1.15
// (32768 = 1.0, truncated), out_tuser flags an empty union (ratio then 0).
//
// Throughput: one word per cycle while the receiver does not stall. The
// pipeline is mostly the divider, one restoring quotient bit per stage
// over 16 stages, behind four stages of corner, extent, product and union
// arithmetic.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output stage.
// When the receiver stalls, the output register holds its word and a skid
// register catches the one word still leaving the pipeline; in_tready then
// drops and the whole pipeline freezes until the skid register drains.
// in_tready is a register output, not a function of out_tready.
module box_pair_iou (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // a_center_x[15:0], a_center_y[31:16], a_width[46:32], a_height[61:47],
  // b_center_x[77:62], b_center_y[93:78], b_width[108:94], b_height[123:109],
  // zero [127:124]
  input  logic [bpiou_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // overlap_ratio[15:0]
  output logic [bpiou_pkg::OUT_W-1:0] out_tdata,
  // empty_union[0]
  output logic                       out_tuser
);
  import bpiou_pkg::*;

  logic en;  // pipeline advance

  // ---- field unpack
  logic signed [CW-1:0] acx, acy, bcx, bcy;
  logic        [SW-1:0] aw, ah, bw, bh;

  assign acx = in_tdata[15:0];
  assign acy = in_tdata[31:16];
  assign aw  = in_tdata[46:32];
  assign ah  = in_tdata[61:47];
  assign bcx = in_tdata[77:62];
  assign bcy = in_tdata[93:78];
  assign bw  = in_tdata[108:94];
  assign bh  = in_tdata[123:109];

  // ---- stage 1: doubled corners, box areas
  logic                    s1_v_r;
  logic signed [CRN_W-1:0] s1_xlo_r, s1_xhi_r, s1_ylo_r, s1_yhi_r;
  logic        [AREA_W-1:0] s1_aarea_r, s1_barea_r;

  logic signed [CRN_W-1:0] a_xlo, a_xhi, a_ylo, a_yhi, b_xlo, b_xhi, b_ylo, b_yhi;
  logic signed [CRN_W-1:0] s1_xlo_nxt, s1_xhi_nxt, s1_ylo_nxt, s1_yhi_nxt;
  logic [2*SW-1:0]         a_prod, b_prod;

  always_comb begin
    a_xlo = (CRN_W'(acx) <<< 1) - $signed(CRN_W'(aw));
    a_xhi = (CRN_W'(acx) <<< 1) + $signed(CRN_W'(aw));
    a_ylo = (CRN_W'(acy) <<< 1) - $signed(CRN_W'(ah));
    a_yhi = (CRN_W'(acy) <<< 1) + $signed(CRN_W'(ah));
    b_xlo = (CRN_W'(bcx) <<< 1) - $signed(CRN_W'(bw));
    b_xhi = (CRN_W'(bcx) <<< 1) + $signed(CRN_W'(bw));
    b_ylo = (CRN_W'(bcy) <<< 1) - $signed(CRN_W'(bh));
    b_yhi = (CRN_W'(bcy) <<< 1) + $signed(CRN_W'(bh));
    // intersection corners
    s1_xlo_nxt = (a_xlo > b_xlo) ? a_xlo : b_xlo;
    s1_xhi_nxt = (a_xhi < b_xhi) ? a_xhi : b_xhi;
    s1_ylo_nxt = (a_ylo > b_ylo) ? a_ylo : b_ylo;
    s1_yhi_nxt = (a_yhi < b_yhi) ? a_yhi : b_yhi;
    a_prod = (2*SW)'(aw) * (2*SW)'(ah);
    b_prod = (2*SW)'(bw) * (2*SW)'(bh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
    if (en) begin
      s1_xlo_r   <= s1_xlo_nxt;
      s1_xhi_r   <= s1_xhi_nxt;
      s1_ylo_r   <= s1_ylo_nxt;
      s1_yhi_r   <= s1_yhi_nxt;
      s1_aarea_r <= {a_prod, 2'b00};  // (2w)(2h)
      s1_barea_r <= {b_prod, 2'b00};
    end
  end

  // ---- stage 2: clamped extents, area sum
  logic               s2_v_r;
  logic [EXT_W-1:0]   s2_ix_r, s2_iy_r;
  logic [UNI_W-1:0]   s2_sum_r;
  logic signed [CRN_W-1:0] dx, dy;
  logic [EXT_W-1:0]   s2_ix_nxt, s2_iy_nxt;

  always_comb begin
    dx = s1_xhi_r - s1_xlo_r;
    dy = s1_yhi_r - s1_ylo_r;
    s2_ix_nxt = (s1_xhi_r > s1_xlo_r) ? dx[EXT_W-1:0] : '0;
    s2_iy_nxt = (s1_yhi_r > s1_ylo_r) ? dy[EXT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
    if (en) begin
      s2_ix_r  <= s2_ix_nxt;
      s2_iy_r  <= s2_iy_nxt;
      s2_sum_r <= UNI_W'(s1_aarea_r) + UNI_W'(s1_barea_r);
    end
  end

  // ---- stage 3: overlap area
  logic              s3_v_r;
  logic [AREA_W-1:0] s3_inter_r;
  logic [UNI_W-1:0]  s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
    if (en) begin
      s3_inter_r <= AREA_W'(s2_ix_r) * AREA_W'(s2_iy_r);
      s3_sum_r   <= s2_sum_r;
    end
  end

  // ---- stage 4 and divider: union, then one quotient bit per stage
  logic [DIV_STEPS:0] dv_r;
  div_t               dd_r [0:DIV_STEPS];
  div_t               d0_nxt;
  div_t               step_nxt [0:DIV_STEPS-1];
  logic [UNI_W-1:0]   uni;

  always_comb begin
    uni          = s3_sum_r - UNI_W'(s3_inter_r);
    d0_nxt.rem   = REM_W'(s3_inter_r);
    d0_nxt.den   = uni;
    d0_nxt.quo   = '0;
    d0_nxt.empty = (uni == '0);
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      step_nxt[k] = div_step(dd_r[k], (k == 0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DIV_STEPS-1:0], s3_v_r};
    end
    if (en) begin
      dd_r[0] <= d0_nxt;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dd_r[k+1] <= step_nxt[k];
      end
    end
  end

  // ---- output register with skid
  res_t push_res;
  logic push;
  logic out_v_r, skid_v_r;
  res_t out_r, skid_r;

  assign push_res.ratio = dd_r[DIV_STEPS].empty ? '0 : dd_r[DIV_STEPS].quo;
  assign push_res.empty = dd_r[DIV_STEPS].empty;
  assign en   = !skid_v_r;
  assign push = en && dv_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
    if (out_tready || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.ratio;
  assign out_tuser  = out_r.empty;

  // ---- checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("pipeline pushed into full output stage");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.ratio <= RATIO_ONE))
    else $error("ratio above one");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.empty) |-> (out_r.ratio == '0))
    else $error("empty union with nonzero ratio");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(rst_n)) |=> $stable(dv_r))
    else $error("pipeline moved while frozen");

endmodule
